FILE: rtl/tmcl_pkg.sv
// ----------------------------------------------------------------------------
// tmcl_pkg - shared types, constants and tables of the mip chain layout unit
// Encoding classes, block footprints, bytes per block, reciprocal constants
// for the block division, register indexes and the controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package tmcl_pkg;

   // Geometry and field widths
   localparam int DIM_BITS_DEFAULT = 15;
   localparam int MAX_MIPS         = 15;
   localparam int CUBE_FACES       = 6;

   localparam int OUT_W       = 15;  // active and stored size fields
   localparam int LEN_W       = 33;
   localparam int OFF_W       = 36;
   localparam int CLS_W       = 4;
   localparam int FP_W        = 3;
   localparam int MIPC_W      = 4;
   localparam int MIPS_W      = 5;   // mip count plus one headroom bit
   localparam int FACE_W      = 3;
   localparam int FACES_W     = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 33;
   localparam int NUM_W       = 17;  // dimension plus block rounding term
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 22;
   localparam int WIDE_W      = 37;  // area times bytes before masking
   localparam int BYTES_W     = 5;
   localparam int BLK_W       = 4;
   localparam int BCODE_W     = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENCODING_CLASS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ASTC_FOOTPRINT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIP_COUNT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_IS_CUBEMAP     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EXPECTED_SIZE  = 3'd6;

   // Encoding classes
   localparam logic [CLS_W-1:0] CLS_A8       = 4'd0;
   localparam logic [CLS_W-1:0] CLS_R8       = 4'd1;
   localparam logic [CLS_W-1:0] CLS_RGB8     = 4'd2;
   localparam logic [CLS_W-1:0] CLS_RGBA8    = 4'd3;
   localparam logic [CLS_W-1:0] CLS_ARGB8    = 4'd4;
   localparam logic [CLS_W-1:0] CLS_RGBA4444 = 4'd5;
   localparam logic [CLS_W-1:0] CLS_RGBA32F  = 4'd6;
   localparam logic [CLS_W-1:0] CLS_RGBA16F  = 4'd7;
   localparam logic [CLS_W-1:0] CLS_DXT1     = 4'd8;
   localparam logic [CLS_W-1:0] CLS_DXT5     = 4'd9;
   localparam logic [CLS_W-1:0] CLS_BC7      = 4'd10;
   localparam logic [CLS_W-1:0] CLS_ETC1     = 4'd11;
   localparam logic [CLS_W-1:0] CLS_ETC2     = 4'd12;
   localparam logic [CLS_W-1:0] CLS_ASTC_LDR = 4'd13;
   localparam logic [CLS_W-1:0] CLS_ASTC_HDR = 4'd14;

   // ASTC footprint codes
   localparam logic [FP_W-1:0] FP_4X4   = 3'd0;
   localparam logic [FP_W-1:0] FP_5X5   = 3'd1;
   localparam logic [FP_W-1:0] FP_6X6   = 3'd2;
   localparam logic [FP_W-1:0] FP_8X8   = 3'd3;
   localparam logic [FP_W-1:0] FP_10X10 = 3'd4;

   // Internal block size codes
   localparam logic [BCODE_W-1:0] BLK_1  = 3'd0;
   localparam logic [BCODE_W-1:0] BLK_4  = 3'd1;
   localparam logic [BCODE_W-1:0] BLK_5  = 3'd2;
   localparam logic [BCODE_W-1:0] BLK_6  = 3'd3;
   localparam logic [BCODE_W-1:0] BLK_8  = 3'd4;
   localparam logic [BCODE_W-1:0] BLK_10 = 3'd5;
   localparam logic [BCODE_W-1:0] BLK_12 = 3'd6;

   typedef struct packed {
      logic load;   // word accepted: latch dimensions, apply restart
      logic div;    // block counts
      logic mul;    // block area and stored sizes
      logic len;    // byte length and expected chain total
      logic fin;    // load result register, advance counters
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;   // result register can take a new word
   } dp_status_type;

   function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLS_W-1:0] cls);
      logic [BYTES_W-1:0] b;
      case (cls)
         CLS_A8, CLS_R8:                           b = 5'd1;
         CLS_RGB8:                                 b = 5'd3;
         CLS_RGBA8, CLS_ARGB8:                     b = 5'd4;
         CLS_RGBA4444:                             b = 5'd2;
         CLS_RGBA16F, CLS_DXT1, CLS_ETC1:          b = 5'd8;
         CLS_RGBA32F, CLS_DXT5, CLS_BC7, CLS_ETC2,
         CLS_ASTC_LDR, CLS_ASTC_HDR:               b = 5'd16;
         default:                                  b = 5'd1;
      endcase
      return b;
   endfunction

   function automatic logic [BCODE_W-1:0] block_code(input logic [CLS_W-1:0] cls,
                                                     input logic [FP_W-1:0]  fp);
      logic [BCODE_W-1:0] c;
      case (cls)
         CLS_DXT1, CLS_DXT5, CLS_BC7, CLS_ETC1, CLS_ETC2: c = BLK_4;
         CLS_ASTC_LDR, CLS_ASTC_HDR: begin
            case (fp)
               FP_4X4:   c = BLK_4;
               FP_5X5:   c = BLK_5;
               FP_6X6:   c = BLK_6;
               FP_8X8:   c = BLK_8;
               FP_10X10: c = BLK_10;
               default:  c = BLK_12;
            endcase
         end
         default: c = BLK_1;
      endcase
      return c;
   endfunction

   function automatic logic [BLK_W-1:0] block_size(input logic [BCODE_W-1:0] code);
      logic [BLK_W-1:0] s;
      case (code)
         BLK_4:   s = 4'd4;
         BLK_5:   s = 4'd5;
         BLK_6:   s = 4'd6;
         BLK_8:   s = 4'd8;
         BLK_10:  s = 4'd10;
         BLK_12:  s = 4'd12;
         default: s = 4'd1;
      endcase
      return s;
   endfunction

   // ceil(2^22 / block size); exact floor quotient for numerators below 2^17
   function automatic logic [RECIP_W-1:0] block_recip(input logic [BCODE_W-1:0] code);
      logic [RECIP_W-1:0] r;
      case (code)
         BLK_4:   r = 23'd1048576;
         BLK_5:   r = 23'd838861;
         BLK_6:   r = 23'd699051;
         BLK_8:   r = 23'd524288;
         BLK_10:  r = 23'd419431;
         BLK_12:  r = 23'd349526;
         default: r = 23'd4194304;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/texture_mip_chain_layout_unit.sv
// ----------------------------------------------------------------------------
// texture_mip_chain_layout_unit - texture sub-image layout generator
// Reports size, block-rounded size, byte length and offset of each sub-image
// of a texture, face by face and mip by mip, one result word per request.
// ----------------------------------------------------------------------------
// Every request word yields one result word for the next sub-image of the
// chain (face-major, then mip-major); req_restart rewinds to face 0, mip 0,
// offset 0 first. An accepted word runs through these steps to the result
// register: latch the mip size at acceptance, then divide by the block
// footprint through a reciprocal multiply, multiply out the block area and
// stored sizes, scale by bytes per block, and add the running offset and
// advance the counters, one step per cycle unless the last step stalls.
// The sequencer carries one word at a time and takes the next request only
// after its last step; the result register lets the next word be
// accepted while the previous result waits on rsp_ready, and the last step
// stalls only if that result is still unclaimed. The result of the final
// sub-image sets rsp_last_image and compares the chain total against the
// face count times the expected face size. A 2D texture of 0x0 with a single
// mip returns one empty word. Write the csr_ registers only while idle.
// ----------------------------------------------------------------------------
module texture_mip_chain_layout_unit #(
   parameter int DIM_BITS = tmcl_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_write_en,
   input  logic [tmcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   // result words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tmcl_pkg::FACE_W-1:0]         rsp_face_index,
   output logic [tmcl_pkg::MIPC_W-1:0]         rsp_mip_level,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_active_width,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_active_height,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_stored_width,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_stored_height,
   output logic [tmcl_pkg::LEN_W-1:0]          rsp_data_length,
   output logic [tmcl_pkg::OFF_W-1:0]          rsp_byte_offset,
   output logic                                rsp_last_image,
   output logic                                rsp_size_mismatch,
   output logic                                rsp_empty_texture
);

   tmcl_pkg::dp_cmd_type    cmd;
   tmcl_pkg::dp_status_type status;

   // sequencer: steps one word through the datapath
   tmcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: registers, counters, arithmetic and result register
   tmcl_dp #(
      .DIM_BITS (DIM_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_restart       (req_restart),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_face_index    (rsp_face_index),
      .rsp_mip_level     (rsp_mip_level),
      .rsp_active_width  (rsp_active_width),
      .rsp_active_height (rsp_active_height),
      .rsp_stored_width  (rsp_stored_width),
      .rsp_stored_height (rsp_stored_height),
      .rsp_data_length   (rsp_data_length),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_last_image    (rsp_last_image),
      .rsp_size_mismatch (rsp_size_mismatch),
      .rsp_empty_texture (rsp_empty_texture)
   );

endmodule

FILE: rtl/tmcl_ctrl.sv
// ----------------------------------------------------------------------------
// tmcl_ctrl - sequencer of the mip chain layout unit
// Walks one accepted word through the datapath steps and holds the last
// step until the result register is free.
// ----------------------------------------------------------------------------
module tmcl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output tmcl_pkg::dp_cmd_type   cmd,
   input  tmcl_pkg::dp_status_type status
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_LEN  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_LEN;
         end
         S_LEN: begin
            cmd.len  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the previous word has left the result register
            if (status.out_free) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tmcl_dp.sv
// ----------------------------------------------------------------------------
// tmcl_dp - datapath of the mip chain layout unit
// Configuration registers, face/mip/offset counters, mip size, block
// rounding, byte length, running offset and the result register.
// ----------------------------------------------------------------------------
module tmcl_dp #(
   parameter int DIM_BITS = tmcl_pkg::DIM_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tmcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmcl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_restart,
   input  tmcl_pkg::dp_cmd_type                cmd,
   output tmcl_pkg::dp_status_type             status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [tmcl_pkg::FACE_W-1:0]         rsp_face_index,
   output logic [tmcl_pkg::MIPC_W-1:0]         rsp_mip_level,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_active_width,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_active_height,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_stored_width,
   output logic [tmcl_pkg::OUT_W-1:0]          rsp_stored_height,
   output logic [tmcl_pkg::LEN_W-1:0]          rsp_data_length,
   output logic [tmcl_pkg::OFF_W-1:0]          rsp_byte_offset,
   output logic                                rsp_last_image,
   output logic                                rsp_size_mismatch,
   output logic                                rsp_empty_texture
);

   localparam int PROD_W = tmcl_pkg::NUM_W + tmcl_pkg::RECIP_W;
   localparam int AREA_W = 2 * DIM_BITS;

   // Configuration registers
   logic [tmcl_pkg::CLS_W-1:0]  enc_class_ff;
   logic [tmcl_pkg::FP_W-1:0]   footprint_ff;
   logic [DIM_BITS-1:0]         base_width_ff;
   logic [DIM_BITS-1:0]         base_height_ff;
   logic [tmcl_pkg::MIPC_W-1:0] mip_count_ff;
   logic                        is_cubemap_ff;
   logic [tmcl_pkg::LEN_W-1:0]  expected_ff;

   // Chain counters
   logic [tmcl_pkg::FACE_W-1:0] face_ff, face_in;
   logic [tmcl_pkg::MIPC_W-1:0] mip_ff, mip_in;
   logic [tmcl_pkg::OFF_W-1:0]  offset_ff, offset_in;

   // Work registers
   logic [DIM_BITS-1:0]          aw_ff, ah_ff;
   logic [tmcl_pkg::NUM_W-1:0]   numx_ff, numy_ff;
   logic [tmcl_pkg::BCODE_W-1:0] bcode_ff;
   logic [DIM_BITS-1:0]          bx_ff, by_ff;
   logic [AREA_W-1:0]            area_ff;
   logic [tmcl_pkg::NUM_W-1:0]   stw_ff, sth_ff;
   logic [tmcl_pkg::LEN_W-1:0]   len_ff;
   logic [tmcl_pkg::OFF_W-1:0]   exp_total_ff;

   // Result register
   logic                         rsp_valid_ff;
   logic [tmcl_pkg::FACE_W-1:0]  out_face_ff;
   logic [tmcl_pkg::MIPC_W-1:0]  out_mip_ff;
   logic [tmcl_pkg::OUT_W-1:0]   out_aw_ff, out_ah_ff, out_sw_ff, out_sh_ff;
   logic [tmcl_pkg::LEN_W-1:0]   out_len_ff;
   logic [tmcl_pkg::OFF_W-1:0]   out_off_ff;
   logic                         out_last_ff, out_mismatch_ff, out_empty_ff;

   // Load step
   logic [tmcl_pkg::MIPC_W-1:0]  mip_eff;
   logic [DIM_BITS-1:0]          shw, shh, aw_in, ah_in;
   logic [tmcl_pkg::BCODE_W-1:0] bcode_in;
   logic [tmcl_pkg::NUM_W-1:0]   blk_now;

   assign mip_eff  = req_restart ? '0 : mip_ff;
   assign shw      = base_width_ff >> mip_eff;
   assign shh      = base_height_ff >> mip_eff;
   assign aw_in    = (shw == '0) ? DIM_BITS'(1) : shw;
   assign ah_in    = (shh == '0) ? DIM_BITS'(1) : shh;
   assign bcode_in = tmcl_pkg::block_code(enc_class_ff, footprint_ff);
   assign blk_now  = tmcl_pkg::NUM_W'(tmcl_pkg::block_size(bcode_in));

   // Division step: multiply by the reciprocal of the block size
   logic [tmcl_pkg::RECIP_W-1:0] recip;
   logic [PROD_W-1:0]            prod_x, prod_y;

   assign recip  = tmcl_pkg::block_recip(bcode_ff);
   assign prod_x = PROD_W'(numx_ff) * PROD_W'(recip);
   assign prod_y = PROD_W'(numy_ff) * PROD_W'(recip);

   // Multiply step
   logic [tmcl_pkg::NUM_W-1:0] blk_cur;
   assign blk_cur = tmcl_pkg::NUM_W'(tmcl_pkg::block_size(bcode_ff));

   // Length step
   logic [tmcl_pkg::WIDE_W-1:0] len_wide;
   assign len_wide = tmcl_pkg::WIDE_W'(area_ff)
                   * tmcl_pkg::WIDE_W'(tmcl_pkg::class_bytes(enc_class_ff));

   // Final step
   logic [tmcl_pkg::MIPS_W-1:0]  mips;
   logic [tmcl_pkg::FACES_W-1:0] faces;
   logic [tmcl_pkg::MIPS_W-1:0]  mip_plus;
   logic [tmcl_pkg::FACES_W-1:0] face_plus;
   logic                         mip_end, face_end, last, empty;
   logic [tmcl_pkg::OFF_W-1:0]   total;
   logic [tmcl_pkg::NUM_W-1:0]   aw_ext, ah_ext;

   always_comb begin
      if (mip_count_ff == '0) begin
         mips = tmcl_pkg::MIPS_W'(1);
      end else if (tmcl_pkg::MIPS_W'(mip_count_ff) > tmcl_pkg::MIPS_W'(tmcl_pkg::MAX_MIPS)) begin
         mips = tmcl_pkg::MIPS_W'(tmcl_pkg::MAX_MIPS);
      end else begin
         mips = tmcl_pkg::MIPS_W'(mip_count_ff);
      end
   end

   assign faces     = is_cubemap_ff ? tmcl_pkg::FACES_W'(tmcl_pkg::CUBE_FACES)
                                    : tmcl_pkg::FACES_W'(1);
   assign mip_plus  = tmcl_pkg::MIPS_W'(mip_ff) + tmcl_pkg::MIPS_W'(1);
   assign face_plus = tmcl_pkg::FACES_W'(face_ff) + tmcl_pkg::FACES_W'(1);
   assign mip_end   = (mip_plus >= mips);
   assign face_end  = (face_plus >= faces);
   assign last      = mip_end && face_end;
   assign empty     = !is_cubemap_ff && (base_width_ff == '0) && (base_height_ff == '0)
                   && (mips == tmcl_pkg::MIPS_W'(1));
   assign total     = offset_ff + tmcl_pkg::OFF_W'(len_ff);
   assign aw_ext    = tmcl_pkg::NUM_W'(aw_ff);
   assign ah_ext    = tmcl_pkg::NUM_W'(ah_ff);

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Counter update
   always_comb begin
      face_in   = face_ff;
      mip_in    = mip_ff;
      offset_in = offset_ff;
      if (cmd.load && req_restart) begin
         face_in   = '0;
         mip_in    = '0;
         offset_in = '0;
      end else if (cmd.fin) begin
         if (empty || last) begin
            face_in   = '0;
            mip_in    = '0;
            offset_in = '0;
         end else begin
            offset_in = total;
            if (mip_end) begin
               mip_in  = '0;
               face_in = face_ff + tmcl_pkg::FACE_W'(1);
            end else begin
               mip_in = mip_ff + tmcl_pkg::MIPC_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_class_ff   <= tmcl_pkg::CLS_RGBA8;
         footprint_ff   <= tmcl_pkg::FP_4X4;
         base_width_ff  <= '0;
         base_height_ff <= '0;
         mip_count_ff   <= tmcl_pkg::MIPC_W'(1);
         is_cubemap_ff  <= 1'b0;
         expected_ff    <= '0;
         face_ff        <= '0;
         mip_ff         <= '0;
         offset_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               tmcl_pkg::REG_ENCODING_CLASS: enc_class_ff   <= csr_wdata[tmcl_pkg::CLS_W-1:0];
               tmcl_pkg::REG_ASTC_FOOTPRINT: footprint_ff   <= csr_wdata[tmcl_pkg::FP_W-1:0];
               tmcl_pkg::REG_BASE_WIDTH:     base_width_ff  <= csr_wdata[DIM_BITS-1:0];
               tmcl_pkg::REG_BASE_HEIGHT:    base_height_ff <= csr_wdata[DIM_BITS-1:0];
               tmcl_pkg::REG_MIP_COUNT:      mip_count_ff   <= csr_wdata[tmcl_pkg::MIPC_W-1:0];
               tmcl_pkg::REG_IS_CUBEMAP:     is_cubemap_ff  <= csr_wdata[0];
               tmcl_pkg::REG_EXPECTED_SIZE:  expected_ff    <= csr_wdata[tmcl_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         face_ff   <= face_in;
         mip_ff    <= mip_in;
         offset_ff <= offset_in;
         if (cmd.fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Work registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         aw_ff    <= aw_in;
         ah_ff    <= ah_in;
         bcode_ff <= bcode_in;
         numx_ff  <= tmcl_pkg::NUM_W'(aw_in) + blk_now - tmcl_pkg::NUM_W'(1);
         numy_ff  <= tmcl_pkg::NUM_W'(ah_in) + blk_now - tmcl_pkg::NUM_W'(1);
      end
      if (cmd.div) begin
         bx_ff <= prod_x[tmcl_pkg::RECIP_SHIFT +: DIM_BITS];
         by_ff <= prod_y[tmcl_pkg::RECIP_SHIFT +: DIM_BITS];
      end
      if (cmd.mul) begin
         area_ff <= AREA_W'(bx_ff) * AREA_W'(by_ff);
         stw_ff  <= tmcl_pkg::NUM_W'(bx_ff) * blk_cur;
         sth_ff  <= tmcl_pkg::NUM_W'(by_ff) * blk_cur;
      end
      if (cmd.len) begin
         len_ff <= len_wide[tmcl_pkg::LEN_W-1:0];
         if (is_cubemap_ff) begin
            exp_total_ff <= (tmcl_pkg::OFF_W'(expected_ff) << 2)
                          + (tmcl_pkg::OFF_W'(expected_ff) << 1);
         end else begin
            exp_total_ff <= tmcl_pkg::OFF_W'(expected_ff);
         end
      end
      if (cmd.fin) begin
         if (empty) begin
            out_face_ff     <= '0;
            out_mip_ff      <= '0;
            out_aw_ff       <= '0;
            out_ah_ff       <= '0;
            out_sw_ff       <= '0;
            out_sh_ff       <= '0;
            out_len_ff      <= '0;
            out_off_ff      <= '0;
            out_last_ff     <= 1'b1;
            out_mismatch_ff <= (expected_ff != '0);
            out_empty_ff    <= 1'b1;
         end else begin
            out_face_ff     <= face_ff;
            out_mip_ff      <= mip_ff;
            out_aw_ff       <= aw_ext[tmcl_pkg::OUT_W-1:0];
            out_ah_ff       <= ah_ext[tmcl_pkg::OUT_W-1:0];
            out_sw_ff       <= stw_ff[tmcl_pkg::OUT_W-1:0];
            out_sh_ff       <= sth_ff[tmcl_pkg::OUT_W-1:0];
            out_len_ff      <= len_ff;
            out_off_ff      <= offset_ff;
            out_last_ff     <= last;
            out_mismatch_ff <= last && (total != exp_total_ff);
            out_empty_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_face_index    = out_face_ff;
   assign rsp_mip_level     = out_mip_ff;
   assign rsp_active_width  = out_aw_ff;
   assign rsp_active_height = out_ah_ff;
   assign rsp_stored_width  = out_sw_ff;
   assign rsp_stored_height = out_sh_ff;
   assign rsp_data_length   = out_len_ff;
   assign rsp_byte_offset   = out_off_ff;
   assign rsp_last_image    = out_last_ff;
   assign rsp_size_mismatch = out_mismatch_ff;
   assign rsp_empty_texture = out_empty_ff;

endmodule

FILE: rtl/tmcl_checker.sv
// ----------------------------------------------------------------------------
// tmcl_checker - port-level checks of the mip chain layout unit
// Watches the request and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module tmcl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [tmcl_pkg::FACE_W-1:0]         rsp_face_index,
   input logic [tmcl_pkg::MIPC_W-1:0]         rsp_mip_level,
   input logic [tmcl_pkg::LEN_W-1:0]          rsp_data_length,
   input logic [tmcl_pkg::OFF_W-1:0]          rsp_byte_offset,
   input logic                                rsp_last_image,
   input logic                                rsp_size_mismatch,
   input logic                                rsp_empty_texture
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_offset)
                                  && $stable(rsp_data_length) && $stable(rsp_last_image))
      else $error("result word changed while stalled");

   // one word in flight: no acceptance right after an acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in flight");

   // the chain check only reports on the final sub-image
   a_mismatch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_mismatch |-> rsp_last_image)
      else $error("size mismatch flagged before the final sub-image");

   // an empty texture is a single zero-length word
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_texture |-> rsp_last_image && (rsp_data_length == '0)
                                         && (rsp_byte_offset == '0))
      else $error("empty texture word is not a zero final word");

   // the chain always starts at offset zero
   a_start_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_face_index == '0) && (rsp_mip_level == '0) |-> rsp_byte_offset == '0)
      else $error("first sub-image does not start at offset zero");

endmodule

bind texture_mip_chain_layout_unit tmcl_checker u_tmcl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_face_index    (rsp_face_index),
   .rsp_mip_level     (rsp_mip_level),
   .rsp_data_length   (rsp_data_length),
   .rsp_byte_offset   (rsp_byte_offset),
   .rsp_last_image    (rsp_last_image),
   .rsp_size_mismatch (rsp_size_mismatch),
   .rsp_empty_texture (rsp_empty_texture)
);
